>>> rtl/core/sbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants of the squeeze band detector
// Holds the register map, result codes, controller phases and the command
// and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int WINDOW_DEPTH_DEF  = 64;
  localparam int PRICE_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int LEN_W      = 7;
  localparam int MULT_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CODE_W     = 2;

  localparam logic [LEN_W-1:0]  RST_BB_WINDOW      = 7'd20;
  localparam logic [MULT_W-1:0] RST_BB_MULT        = 4'd2;
  localparam logic [LEN_W-1:0]  RST_KC_WINDOW      = 7'd20;
  localparam logic [MULT_W-1:0] RST_KC_MULT        = 4'd1;
  localparam logic              RST_USE_TRUE_RANGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BB_WINDOW      = 3'd0,
    REG_BB_MULT        = 3'd1,
    REG_KC_WINDOW      = 3'd2,
    REG_KC_MULT        = 3'd3,
    REG_USE_TRUE_RANGE = 3'd4
  } sbd_reg_e;

  typedef enum logic [CODE_W-1:0] {
    SQZ_NONE     = 2'd0,
    SQZ_ON       = 2'd1,
    SQZ_RELEASED = 2'd2
  } sbd_code_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_PREP,
    PH_SUM,
    PH_MULA,
    PH_MULB,
    PH_SQRT,
    PH_DIVBD,
    PH_DIVBM,
    PH_DIVKM,
    PH_DIVKD,
    PH_CMP,
    PH_DONE
  } sbd_state_e;

  typedef struct packed {
    logic [LEN_W-1:0]  bb_window;
    logic [MULT_W-1:0] bb_mult;
    logic [LEN_W-1:0]  kc_window;
    logic [MULT_W-1:0] kc_mult;
    logic              use_true_range;
  } sbd_cfg_t;

  typedef struct packed {
    sbd_state_e phase;
    logic       init;
    logic       accept;
  } sbd_cmd_t;

  typedef struct packed {
    logic      done;
    logic      ready;
    sbd_code_e code;
  } sbd_stat_t;

endpackage

>>> rtl/core/squeeze_band_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// squeeze_band_detector: Bollinger / Keltner squeeze indicator
// One price candle in, one squeeze result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with high, low and close prices; a transfer
//   happens when in_valid_i is high and in_stall_o is low. The block holds
//   in_stall_o high while one candle is in work.
//   Output channel: out_valid_o with squeeze_code_o and bands_ready_o; the
//   receiver holds a result with out_stall_i, and the result stays put.
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (register
//   number) and cfg_data_i; write only while no candle is in work.
// Sequence:
//   During warm-up (bands not ready) the controller goes from PREP straight
//   to DONE, and the next candle can transfer once the result is delivered.
//   A ready candle walks the window sweep, a shift-add multiply over the
//   length and the sum bits, a square root of one bit per cycle, and four
//   divisions of one bit per cycle.
//   One candle is in work at a time; the next one is taken while the last
//   result still sits in the output register.
// Reset clears the window state and loads the register defaults; ring
// entries fill as candles arrive. A stalled receiver parks the result in the
// output register and holds the block after its next candle.
// ----------------------------------------------------------------------------
module squeeze_band_detector import sbd_pkg::*; #(
  parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS    = PRICE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PRICE_BITS-1:0] high_price_i,
  input  logic [PRICE_BITS-1:0] low_price_i,
  input  logic [PRICE_BITS-1:0] close_price_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CODE_W-1:0]     squeeze_code_o,
  output logic                  bands_ready_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  sbd_cfg_t  cfg_q;
  sbd_cmd_t  cmd;
  sbd_stat_t stat;
  logic      out_free, deliver;
  logic      out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  logic      out_ready_q;

  // register file: always ready, unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bb_window      <= RST_BB_WINDOW;
      cfg_q.bb_mult        <= RST_BB_MULT;
      cfg_q.kc_window      <= RST_KC_WINDOW;
      cfg_q.kc_mult        <= RST_KC_MULT;
      cfg_q.use_true_range <= RST_USE_TRUE_RANGE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BB_WINDOW:      cfg_q.bb_window      <= cfg_data_i[LEN_W-1:0];
        REG_BB_MULT:        cfg_q.bb_mult        <= cfg_data_i[MULT_W-1:0];
        REG_KC_WINDOW:      cfg_q.kc_window      <= cfg_data_i[LEN_W-1:0];
        REG_KC_MULT:        cfg_q.kc_mult        <= cfg_data_i[MULT_W-1:0];
        REG_USE_TRUE_RANGE: cfg_q.use_true_range <= cfg_data_i[0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  // the output register frees up when empty or when its transfer completes
  assign out_free = !out_valid_q || !out_stall_i;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .deliver_o  (deliver),
    .cmd_o      (cmd)
  );

  sbd_datapath #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .PRICE_BITS    (PRICE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .high_price_i  (high_price_i),
    .low_price_i   (low_price_i),
    .close_price_i (close_price_i),
    .stat_o        (stat)
  );

  // output register: load a finished result, drop valid after its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      out_code_q  <= stat.code;
      out_ready_q <= stat.ready;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign squeeze_code_o = out_code_q;
  assign bands_ready_o  = out_ready_q;

endmodule

>>> rtl/core/sbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_ctrl: phase sequencer of the squeeze band detector
// Steps a ready candle through sweep, multiply, root, divide and compare.
// ----------------------------------------------------------------------------
module sbd_ctrl import sbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  input  sbd_stat_t stat_i,
  output logic      in_stall_o,
  output logic      deliver_o,
  output sbd_cmd_t  cmd_o
);

  sbd_state_e state_q, state_d;
  logic       first_q, first_d;
  logic       step_done;

  assign step_done = !first_q && stat_i.done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      PH_IDLE:  if (in_valid_i) state_d = PH_PREP;
      PH_PREP:  state_d = stat_i.ready ? PH_SUM : PH_DONE;
      PH_SUM:   if (step_done) state_d = PH_MULA;
      PH_MULA:  if (step_done) state_d = PH_MULB;
      PH_MULB:  if (step_done) state_d = PH_SQRT;
      PH_SQRT:  if (step_done) state_d = PH_DIVBD;
      PH_DIVBD: if (step_done) state_d = PH_DIVBM;
      PH_DIVBM: if (step_done) state_d = PH_DIVKM;
      PH_DIVKM: if (step_done) state_d = PH_DIVKD;
      PH_DIVKD: if (step_done) state_d = PH_CMP;
      PH_CMP:   state_d = PH_DONE;
      PH_DONE:  if (out_free_i) state_d = PH_IDLE;
      default:  state_d = PH_IDLE;
    endcase
  end

  assign first_d = (state_d != state_q);

  always_comb begin
    cmd_o.phase  = state_q;
    cmd_o.init   = first_q;
    cmd_o.accept = (state_q == PH_IDLE) && in_valid_i;
    in_stall_o   = (state_q != PH_IDLE);
    deliver_o    = (state_q == PH_DONE) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

endmodule

>>> rtl/core/sbd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_datapath: rings, window sums and shared serial arithmetic
// Holds the close and range rings, sweeps them for window sums, and runs a
// shift-add multiplier, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
module sbd_datapath import sbd_pkg::*; #(
  parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS    = PRICE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbd_cmd_t              cmd_i,
  input  sbd_cfg_t              cfg_i,
  input  logic [PRICE_BITS-1:0] high_price_i,
  input  logic [PRICE_BITS-1:0] low_price_i,
  input  logic [PRICE_BITS-1:0] close_price_i,
  output sbd_stat_t             stat_o
);

  localparam int P    = PRICE_BITS;
  localparam int LG   = $clog2(WINDOW_DEPTH);
  localparam int LW   = $clog2(WINDOW_DEPTH + 1);
  localparam int SW   = $clog2(WINDOW_DEPTH + 2);
  localparam int S    = P + LG;
  localparam int Q    = 2 * P + LG;
  localparam int VW   = 2 * P + 2 * LG + 2;
  localparam int RW   = P + LG + 1 + FRACTION_BITS;
  localparam int NW   = RW;
  localparam int RADW = 2 * RW;
  localparam int CW   = $clog2(RW + 1);
  localparam int CPW  = NW + MULT_W + 1;

  function automatic logic [LW-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LW-1:0] r;
    if (v == '0) begin
      r = LW'(1);
    end else if (int'(v) > WINDOW_DEPTH) begin
      r = LW'(WINDOW_DEPTH);
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  function automatic logic [P-1:0] absdiff(input logic [P-1:0] a, input logic [P-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [LW-1:0] bl, kl, kmax, divisor;

  assign bl      = clamp_len(cfg_i.bb_window);
  assign kl      = clamp_len(cfg_i.kc_window);
  assign kmax    = (bl > kl) ? bl : kl;
  assign divisor = (cmd_i.phase == PH_DIVBD || cmd_i.phase == PH_DIVBM) ? bl : kl;

  // candle state
  logic [LG-1:0] head_q, head_d;
  logic [SW-1:0] seen_q, seen_d;
  logic [P-1:0]  prev_q;
  logic          ready_q;
  sbd_code_e     code_q, code_d;
  logic [P-1:0]  range_w, hl, hp, lp;

  always_comb begin
    hl      = absdiff(high_price_i, low_price_i);
    hp      = absdiff(high_price_i, prev_q);
    lp      = absdiff(low_price_i, prev_q);
    range_w = '0;
    if (seen_q != '0) begin
      range_w = hl;
      if (cfg_i.use_true_range) begin
        if (hp > range_w) range_w = hp;
        if (lp > range_w) range_w = lp;
      end
    end
    head_d = (head_q == LG'(WINDOW_DEPTH - 1)) ? '0 : head_q + LG'(1);
    seen_d = (seen_q == SW'(WINDOW_DEPTH + 1)) ? seen_q : seen_q + SW'(1);
  end

  // window sweep
  logic [SW-1:0]  k_q;
  logic           v1_q, bb1_q, kc1_q, v2_q, bb2_q, kc2_q;
  logic [P-1:0]   cl2_q, rg2_q;
  logic [2*P-1:0] sq2_q;
  logic [S-1:0]   bbs_q, kcs_q, rgs_q;
  logic [Q-1:0]   bbsq_q;
  logic           issue, sum_done;
  logic [LG+1:0]  addr_wide;
  logic [LG-1:0]  raddr;
  logic [P-1:0]   close_rd, range_rd;

  assign issue    = (cmd_i.phase == PH_SUM) && !cmd_i.init && (k_q <= SW'(kmax));
  assign sum_done = (k_q > SW'(kmax)) && !v1_q && !v2_q;

  always_comb begin
    addr_wide = (LG+2)'(head_q) + (LG+2)'(WINDOW_DEPTH) - (LG+2)'(k_q);
    if (addr_wide >= (LG+2)'(WINDOW_DEPTH)) begin
      addr_wide = addr_wide - (LG+2)'(WINDOW_DEPTH);
    end
    raddr = addr_wide[LG-1:0];
  end

  sbd_ram #(.WIDTH(P), .DEPTH(WINDOW_DEPTH)) u_close_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (head_q),
    .wdata_i (close_price_i),
    .raddr_i (raddr),
    .rdata_o (close_rd)
  );

  sbd_ram #(.WIDTH(P), .DEPTH(WINDOW_DEPTH)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (head_q),
    .wdata_i (range_w),
    .raddr_i (raddr),
    .rdata_o (range_rd)
  );

  // serial arithmetic
  logic [VW-1:0]   acc_q, mcand_q;
  logic [S-1:0]    mplier_q;
  logic [RADW-1:0] rad_q;
  logic [RW+1:0]   rem_q, rem_n;
  logic [RW-1:0]   root_q, root_n;
  logic [NW-1:0]   num_q, num_n;
  logic [LW-1:0]   drem_q, drem_n;
  logic [CW-1:0]   cnt_q;
  logic [NW-1:0]   bd_q, bm_q, km_q, kd_q;
  logic [RW+3:0]   remx, trial;
  logic [LW:0]     dtry;
  logic            dge;

  always_comb begin
    remx  = {rem_q, rad_q[RADW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    if (remx >= trial) begin
      rem_n  = (RW+2)'(remx - trial);
      root_n = {root_q[RW-2:0], 1'b1};
    end else begin
      rem_n  = (RW+2)'(remx);
      root_n = {root_q[RW-2:0], 1'b0};
    end
    dtry   = {drem_q, num_q[NW-1]};
    dge    = (dtry >= {1'b0, divisor});
    drem_n = dge ? LW'(dtry - {1'b0, divisor}) : LW'(dtry);
    num_n  = {num_q[NW-2:0], dge};
  end

  // compare the bands
  logic [CPW-1:0] bdev, kdev, a1, b1, a2, b2;

  always_comb begin
    bdev   = CPW'(cfg_i.bb_mult) * CPW'(bd_q);
    kdev   = CPW'(cfg_i.kc_mult) * CPW'(kd_q);
    a1     = CPW'(bm_q) + kdev;
    b1     = CPW'(km_q) + bdev;
    a2     = CPW'(bm_q) + bdev;
    b2     = CPW'(km_q) + kdev;
    code_d = SQZ_NONE;
    if (a1 > b1 && a2 < b2) begin
      code_d = SQZ_ON;
    end else if (a1 < b1 && a2 > b2) begin
      code_d = SQZ_RELEASED;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      seen_q  <= '0;
      prev_q  <= '0;
      ready_q <= 1'b0;
      code_q  <= SQZ_NONE;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        head_q  <= head_d;
        seen_q  <= seen_d;
        prev_q  <= close_price_i;
        ready_q <= (seen_d > SW'(bl)) && (seen_d > SW'(kl));
        code_q  <= SQZ_NONE;
      end
      if (cmd_i.phase == PH_CMP) begin
        code_q <= code_d;
      end
      if (cmd_i.phase == PH_SUM && cmd_i.init) begin
        k_q  <= SW'(1);
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end else begin
        if (issue) k_q <= k_q + SW'(1);
        v1_q <= issue;
        v2_q <= v1_q;
      end
      if (cmd_i.init) begin
        case (cmd_i.phase)
          PH_MULA:  cnt_q <= CW'(LW - 1);
          PH_MULB:  cnt_q <= CW'(S - 1);
          PH_SQRT:  cnt_q <= CW'(RW - 1);
          PH_DIVBD,
          PH_DIVBM,
          PH_DIVKM,
          PH_DIVKD: cnt_q <= CW'(NW - 1);
          default:  cnt_q <= cnt_q;
        endcase
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    bb1_q <= (k_q <= SW'(bl));
    kc1_q <= (k_q <= SW'(kl));
    bb2_q <= bb1_q;
    kc2_q <= kc1_q;
    cl2_q <= close_rd;
    rg2_q <= range_rd;
    sq2_q <= (2*P)'(close_rd) * (2*P)'(close_rd);
    case (cmd_i.phase)
      PH_SUM: begin
        if (cmd_i.init) begin
          bbs_q  <= '0;
          bbsq_q <= '0;
          kcs_q  <= '0;
          rgs_q  <= '0;
        end else if (v2_q) begin
          if (bb2_q) begin
            bbs_q  <= bbs_q + S'(cl2_q);
            bbsq_q <= bbsq_q + Q'(sq2_q);
          end
          if (kc2_q) begin
            kcs_q <= kcs_q + S'(cl2_q);
            rgs_q <= rgs_q + S'(rg2_q);
          end
        end
      end
      PH_MULA: begin
        if (cmd_i.init) begin
          acc_q    <= '0;
          mcand_q  <= VW'(bbsq_q);
          mplier_q <= S'(bl);
        end else begin
          if (mplier_q[0]) acc_q <= acc_q + mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      PH_MULB: begin
        if (cmd_i.init) begin
          mcand_q  <= VW'(bbs_q);
          mplier_q <= bbs_q;
        end else begin
          if (mplier_q[0]) acc_q <= acc_q - mcand_q;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      PH_SQRT: begin
        if (cmd_i.init) begin
          rad_q  <= RADW'(acc_q) << (2 * FRACTION_BITS);
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          rad_q  <= rad_q << 2;
          rem_q  <= rem_n;
          root_q <= root_n;
        end
      end
      PH_DIVBD,
      PH_DIVBM,
      PH_DIVKM,
      PH_DIVKD: begin
        if (cmd_i.init) begin
          drem_q <= '0;
          case (cmd_i.phase)
            PH_DIVBD: num_q <= NW'(root_q);
            PH_DIVBM: num_q <= NW'(bbs_q) << FRACTION_BITS;
            PH_DIVKM: num_q <= NW'(kcs_q) << FRACTION_BITS;
            default:  num_q <= NW'(rgs_q) << FRACTION_BITS;
          endcase
        end else begin
          drem_q <= drem_n;
          num_q  <= num_n;
          if (cnt_q == '0) begin
            case (cmd_i.phase)
              PH_DIVBD: bd_q <= num_n;
              PH_DIVBM: bm_q <= num_n;
              PH_DIVKM: km_q <= num_n;
              default:  kd_q <= num_n;
            endcase
          end
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.phase)
      PH_SUM:   stat_o.done = sum_done;
      PH_MULA,
      PH_MULB,
      PH_SQRT,
      PH_DIVBD,
      PH_DIVBM,
      PH_DIVKM,
      PH_DIVKD: stat_o.done = (cnt_q == '0);
      default:  stat_o.done = 1'b1;
    endcase
    stat_o.ready = ready_q;
    stat_o.code  = code_q;
  end

endmodule

>>> rtl/core/sbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_checker: port-level checks of the squeeze band detector
// Watches both channels and the result fields over time.
// ----------------------------------------------------------------------------
module sbd_checker import sbd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CODE_W-1:0] squeeze_code_o,
  input logic              bands_ready_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(squeeze_code_o)
      && $stable(bands_ready_o))
    else $error("stalled result changed");

  // no squeeze verdict before the bands are defined
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bands_ready_o |-> squeeze_code_o == SQZ_NONE)
    else $error("squeeze reported before bands ready");

  // one candle in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second candle taken while one is in work");

  // a result never appears in the cycle right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind squeeze_band_detector sbd_checker u_sbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .squeeze_code_o (squeeze_code_o),
  .bands_ready_o  (bands_ready_o)
);
